// File: design/ipv4p_pkg.sv
// Package for the IPv4 dotted address parser: phase, radix and verdict codes,
// the parser state type and the helper functions shared by the step logic.
// No dependencies.
package ipv4p_pkg;

  // Largest number of dot-separated parts and the index width for the stored ones
  localparam int unsigned MAX_PARTS  = 4;
  localparam int unsigned PART_IDX_W = 2;

  // Parse phase codes
  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_ZERO    = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_SETTLED = 2'd3;

  // Radix codes
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  // Verdict codes
  localparam logic [1:0] VD_OPEN = 2'd0;
  localparam logic [1:0] VD_PASS = 2'd1;
  localparam logic [1:0] VD_FAIL = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  // Range limits for the last part, by number of earlier parts
  localparam logic [31:0] LIM_24 = 32'h00FF_FFFF;
  localparam logic [31:0] LIM_16 = 32'h0000_FFFF;
  localparam logic [31:0] LIM_8  = 32'h0000_00FF;

  typedef struct packed {
    logic [1:0]            phase;
    logic [1:0]            radix;
    logic [31:0]           acc;
    logic [PART_IDX_W-1:0] part_count;
    logic [1:0]            verdict;
  } state_t;

  // Stored earlier parts, one word per part before the last
  typedef logic [MAX_PARTS-2:0][31:0] parts_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_START,
    radix:      RX_DEC,
    acc:        32'd0,
    part_count: '0,
    verdict:    VD_OPEN
  };

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_lower_hex(input logic [7:0] c);
    return (c >= CH_LOWER_A) && (c <= CH_LOWER_F);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c >= CH_UPPER_A) && (c <= CH_UPPER_F);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic state_t settle_fail(input state_t s);
    state_t r;
    r         = s;
    r.verdict = VD_FAIL;
    r.phase   = PH_SETTLED;
    return r;
  endfunction

  // Terminator seen: range check the last part and OR the shifted earlier
  // parts in; earlier parts are not range checked, so their upper bits spill
  function automatic state_t finish_text(input state_t s, input parts_t p);
    state_t      r;
    logic [31:0] v;
    logic        bad;
    r   = s;
    v   = s.acc;
    bad = 1'b0;
    case (s.part_count)
      2'd1: begin
        bad = (v > LIM_24);
        v   = v | (p[0] << 24);
      end
      2'd2: begin
        bad = (v > LIM_16);
        v   = v | (p[0] << 24) | (p[1] << 16);
      end
      2'd3: begin
        bad = (v > LIM_8);
        v   = v | (p[0] << 24) | (p[1] << 16) | (p[2] << 8);
      end
      default: begin
        bad = 1'b0;
      end
    endcase
    if (bad) begin
      r = settle_fail(s);
    end else begin
      r.acc     = v;
      r.verdict = VD_PASS;
      r.phase   = PH_SETTLED;
    end
    return r;
  endfunction

  function automatic logic [31:0] byte_swap(input logic [31:0] n);
    return {n[7:0], n[15:8], n[23:16], n[31:24]};
  endfunction

endpackage

// File: design/ipv4_dotted_address_parser_core.sv
// Top level of the IPv4 dotted address parser: input register, parser state,
// stored parts and result register. Uses ipv4p_pkg and ipv4p_step.
//
// Takes an address text one character per beat (inet_aton rules: decimal,
// octal after a leading 0, hex after 0x; one to four dot-separated parts) and
// on the beat marked end_of_string gives one result: valid_res and the address
// in network byte order (zero when the text does not parse). One character is
// accepted every cycle while no end-of-text beat is held; the last character
// passes through the input register and its result into the result register. An
// end-of-text beat waits in the input register, holding off further characters,
// while the previous result is still unaccepted. The rate is set by the parser
// state update, whose combinational step covers one character's step as well as
// the closing range check and packing. The parser returns to its reset state
// after each text.
module ipv4_dotted_address_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [31:0] address_o
);

  logic                             in_valid_q;
  logic [7:0]                       char_q;
  logic                             eos_q;
  logic                             advance;
  logic                             in_fire;

  ipv4p_pkg::state_t                state_q;
  ipv4p_pkg::state_t                state_d;
  ipv4p_pkg::parts_t                parts_q;
  logic                             part_we;
  logic [ipv4p_pkg::PART_IDX_W-1:0] part_idx;
  logic [31:0]                      part_data;
  logic                             step_valid_res;
  logic [31:0]                      step_address;

  logic                             out_valid_q;
  logic                             valid_res_q;
  logic [31:0]                      address_q;

  // Beat in the input register moves on unless it carries a result and the
  // result register is still full
  assign advance    = in_valid_q && (!eos_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_code_i;
      eos_q  <= end_of_string_i;
    end
  end

  // Parser step
  ipv4p_step u_step (
    .state_i     (state_q),
    .parts_i     (parts_q),
    .char_i      (char_q),
    .eos_i       (eos_q),
    .state_o     (state_d),
    .part_we_o   (part_we),
    .part_idx_o  (part_idx),
    .part_data_o (part_data),
    .valid_res_o (step_valid_res),
    .address_o   (step_address)
  );

  // Parser state; back to reset after each text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipv4p_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= eos_q ? ipv4p_pkg::STATE_RESET : state_d;
    end
  end

  // Earlier parts, written on each dot that opens a new part
  always_ff @(posedge clk_i) begin
    if (advance && part_we) begin
      parts_q[part_idx] <= part_data;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && eos_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && eos_q) begin
      valid_res_q <= step_valid_res;
      address_q   <= step_address;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign address_o   = address_q;

endmodule

// File: design/ipv4p_step.sv
// Next-state logic for one character beat of the address parser, plus the
// end-of-text terminator and the result word. Uses ipv4p_pkg.
module ipv4p_step (
  input  ipv4p_pkg::state_t                   state_i,
  input  ipv4p_pkg::parts_t                   parts_i,
  input  logic [7:0]                          char_i,
  input  logic                                eos_i,
  output ipv4p_pkg::state_t                   state_o,
  output logic                                part_we_o,
  output logic [ipv4p_pkg::PART_IDX_W-1:0]    part_idx_o,
  output logic [31:0]                         part_data_o,
  output logic                                valid_res_o,
  output logic [31:0]                         address_o
);

  ipv4p_pkg::state_t s;
  logic              in_digits;
  logic [31:0]       acc_scaled;
  logic [31:0]       digit;

  // Accumulator times the radix: shifts and one add
  always_comb begin
    case (s.radix)
      ipv4p_pkg::RX_HEX: acc_scaled = {s.acc[27:0], 4'd0};
      ipv4p_pkg::RX_OCT: acc_scaled = {s.acc[28:0], 3'd0};
      default:           acc_scaled = {s.acc[28:0], 3'd0} + {s.acc[30:0], 1'b0};
    endcase
  end

  // Value of a decimal or hex digit character
  always_comb begin
    if (ipv4p_pkg::is_dec(char_i)) begin
      digit = {24'd0, char_i - ipv4p_pkg::CH_ZERO};
    end else if (ipv4p_pkg::is_lower_hex(char_i)) begin
      digit = {24'd0, char_i - ipv4p_pkg::CH_LOWER_A + 8'd10};
    end else begin
      digit = {24'd0, char_i - ipv4p_pkg::CH_UPPER_A + 8'd10};
    end
  end

  // Character step followed by the terminator when the beat ends the text.
  // s holds the state after the prefix handling of the leading zero.
  always_comb begin
    s           = state_i;
    in_digits   = 1'b0;
    if (state_i.phase == ipv4p_pkg::PH_ZERO) begin
      s.phase = ipv4p_pkg::PH_DIGITS;
      s.radix = ((char_i == ipv4p_pkg::CH_LOWER_X) || (char_i == ipv4p_pkg::CH_UPPER_X)) ?
                ipv4p_pkg::RX_HEX : ipv4p_pkg::RX_OCT;
    end
    state_o     = s;
    part_we_o   = 1'b0;
    part_idx_o  = state_i.part_count;
    part_data_o = state_i.acc;

    case (state_i.phase)
      ipv4p_pkg::PH_START: begin
        if (!ipv4p_pkg::is_dec(char_i)) begin
          state_o = ipv4p_pkg::settle_fail(state_i);
        end else if (char_i == ipv4p_pkg::CH_ZERO) begin
          state_o.acc   = 32'd0;
          state_o.radix = ipv4p_pkg::RX_OCT;
          state_o.phase = ipv4p_pkg::PH_ZERO;
        end else begin
          state_o.acc   = digit;
          state_o.radix = ipv4p_pkg::RX_DEC;
          state_o.phase = ipv4p_pkg::PH_DIGITS;
        end
      end
      ipv4p_pkg::PH_ZERO: begin
        in_digits = (s.radix != ipv4p_pkg::RX_HEX);
      end
      ipv4p_pkg::PH_DIGITS: begin
        in_digits = 1'b1;
      end
      default: begin
        in_digits = 1'b0;
      end
    endcase

    if (in_digits) begin
      if (ipv4p_pkg::is_dec(char_i) ||
          ((s.radix == ipv4p_pkg::RX_HEX) &&
           (ipv4p_pkg::is_lower_hex(char_i) || ipv4p_pkg::is_upper_hex(char_i)))) begin
        state_o.acc = acc_scaled + digit;
      end else if (char_i == ipv4p_pkg::CH_DOT) begin
        if (s.part_count == ipv4p_pkg::PART_IDX_W'(ipv4p_pkg::MAX_PARTS - 1)) begin
          state_o = ipv4p_pkg::settle_fail(s);
        end else begin
          part_we_o          = 1'b1;
          state_o.part_count = s.part_count + 1'b1;
          state_o.acc        = 32'd0;
          state_o.radix      = ipv4p_pkg::RX_DEC;
          state_o.phase      = ipv4p_pkg::PH_START;
        end
      end else if ((char_i == ipv4p_pkg::CH_NUL) || ipv4p_pkg::is_space(char_i)) begin
        state_o = ipv4p_pkg::finish_text(s, parts_i);
      end else begin
        state_o = ipv4p_pkg::settle_fail(s);
      end
    end

    // End of text acts as a NUL terminator
    if (eos_i) begin
      case (state_o.phase)
        ipv4p_pkg::PH_START:   state_o = ipv4p_pkg::settle_fail(state_o);
        ipv4p_pkg::PH_ZERO,
        ipv4p_pkg::PH_DIGITS:  state_o = ipv4p_pkg::finish_text(state_o, parts_i);
        default:               state_o = state_o;
      endcase
    end
  end

  // Result word in network byte order, zero on failure
  assign valid_res_o = (state_o.verdict == ipv4p_pkg::VD_PASS);
  assign address_o   = valid_res_o ? ipv4p_pkg::byte_swap(state_o.acc) : 32'd0;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for ipv4_dotted_address_parser_core: directed and random address
// texts checked against a predictor, with random idling on both channels.
// Depends on ipv4p_pkg and the core module.
module tb;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } address_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_code_i;
  logic        end_of_string_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        valid_res_o;
  logic [31:0] address_o;

  // Predicted results, oldest first
  address_result_t expected_addresses[$];
  address_result_t oldest;
  int unsigned     fail_count;
  int unsigned     chars_sent;
  bit              send_gaps;
  bit              take_gaps;
  int unsigned     hold_req;
  logic [7:0]      text_buf[$];

  // Predictor state
  logic [1:0]  p_phase;
  logic [1:0]  p_radix;
  logic [1:0]  p_verdict;
  logic [31:0] p_acc;
  logic [31:0] p_parts[3];
  int unsigned p_nparts;

  ipv4_dotted_address_parser_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .valid_res_o     (valid_res_o),
    .address_o       (address_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_numeral(input logic [7:0] c);
    return (c >= ipv4p_pkg::CH_ZERO) && (c <= ipv4p_pkg::CH_NINE);
  endfunction

  task automatic clear_parser();
    p_phase   = ipv4p_pkg::PH_START;
    p_radix   = ipv4p_pkg::RX_DEC;
    p_verdict = ipv4p_pkg::VD_OPEN;
    p_acc     = '0;
    p_nparts  = 0;
  endtask

  task automatic mark_failed();
    p_verdict = ipv4p_pkg::VD_FAIL;
    p_phase   = ipv4p_pkg::PH_SETTLED;
  endtask

  // Last part ended: range check against its field, then OR the shifted
  // earlier parts in, upper bits and all
  task automatic close_address();
    logic [31:0] lim;
    logic [31:0] lead;
    case (p_nparts)
      1: begin
        lim  = ipv4p_pkg::LIM_24;
        lead = p_parts[0] << 24;
      end
      2: begin
        lim  = ipv4p_pkg::LIM_16;
        lead = (p_parts[0] << 24) | (p_parts[1] << 16);
      end
      3: begin
        lim  = ipv4p_pkg::LIM_8;
        lead = (p_parts[0] << 24) | (p_parts[1] << 16) | (p_parts[2] << 8);
      end
      default: begin
        lim  = 32'hFFFF_FFFF;
        lead = '0;
      end
    endcase
    if (p_acc > lim) begin
      mark_failed();
    end else begin
      p_acc     = p_acc | lead;
      p_verdict = ipv4p_pkg::VD_PASS;
      p_phase   = ipv4p_pkg::PH_SETTLED;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [31:0] weight;
    logic [7:0]  nib;
    if (p_phase == ipv4p_pkg::PH_SETTLED) return;
    if (p_phase == ipv4p_pkg::PH_START) begin
      if (!is_numeral(c)) begin
        mark_failed();
      end else if (c == ipv4p_pkg::CH_ZERO) begin
        p_acc   = '0;
        p_radix = ipv4p_pkg::RX_OCT;
        p_phase = ipv4p_pkg::PH_ZERO;
      end else begin
        p_acc   = {24'h0, c - ipv4p_pkg::CH_ZERO};
        p_radix = ipv4p_pkg::RX_DEC;
        p_phase = ipv4p_pkg::PH_DIGITS;
      end
      return;
    end
    // after a leading zero, an x or X selects hex and any other character is taken in octal
    if (p_phase == ipv4p_pkg::PH_ZERO) begin
      p_phase = ipv4p_pkg::PH_DIGITS;
      if (c == ipv4p_pkg::CH_LOWER_X || c == ipv4p_pkg::CH_UPPER_X) begin
        p_radix = ipv4p_pkg::RX_HEX;
        return;
      end
      p_radix = ipv4p_pkg::RX_OCT;
    end
    case (p_radix)
      ipv4p_pkg::RX_HEX: weight = 32'd16;
      ipv4p_pkg::RX_OCT: weight = 32'd8;
      default:           weight = 32'd10;
    endcase
    if (is_numeral(c)) begin
      p_acc = p_acc * weight + {24'h0, c - ipv4p_pkg::CH_ZERO};
    end else if (p_radix == ipv4p_pkg::RX_HEX &&
                 c >= ipv4p_pkg::CH_LOWER_A && c <= ipv4p_pkg::CH_LOWER_F) begin
      nib   = c - ipv4p_pkg::CH_LOWER_A + 8'd10;
      p_acc = {p_acc[27:0], nib[3:0]};
    end else if (p_radix == ipv4p_pkg::RX_HEX &&
                 c >= ipv4p_pkg::CH_UPPER_A && c <= ipv4p_pkg::CH_UPPER_F) begin
      nib   = c - ipv4p_pkg::CH_UPPER_A + 8'd10;
      p_acc = {p_acc[27:0], nib[3:0]};
    end else if (c == ipv4p_pkg::CH_DOT) begin
      if (p_nparts >= ipv4p_pkg::MAX_PARTS - 1) begin
        mark_failed();
      end else begin
        p_parts[p_nparts] = p_acc;
        p_nparts++;
        p_acc   = '0;
        p_radix = ipv4p_pkg::RX_DEC;
        p_phase = ipv4p_pkg::PH_START;
      end
    end else if (c == ipv4p_pkg::CH_NUL || c == ipv4p_pkg::CH_SPACE ||
                 (c >= ipv4p_pkg::CH_TAB && c <= ipv4p_pkg::CH_CR)) begin
      close_address();
    end else begin
      mark_failed();
    end
  endtask

  // One accepted beat; the end marker acts as a trailing NUL
  task automatic predict_beat(input logic [7:0] c, input bit eos);
    address_result_t r;
    parse_char(c);
    if (eos) begin
      parse_char(ipv4p_pkg::CH_NUL);
      r.ok   = (p_verdict == ipv4p_pkg::VD_PASS);
      r.addr = r.ok ? {p_acc[7:0], p_acc[15:8], p_acc[23:16], p_acc[31:24]} : '0;
      expected_addresses.push_back(r);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------- sender

  task automatic send_char(input logic [7:0] c, input bit eos);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    char_code_i     = c;
    end_of_string_i = eos;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(c, eos);
    chars_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic put_str(input string s);
    for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
  endtask

  // Empty text goes out as a lone NUL carrying the end marker
  task automatic send_text_buf();
    if (text_buf.size() == 0) begin
      send_char(ipv4p_pkg::CH_NUL, 1'b1);
    end else begin
      for (int k = 0; k < text_buf.size(); k++) begin
        send_char(text_buf[k], k == text_buf.size() - 1);
      end
    end
  endtask

  task automatic send_str(input string s);
    text_buf = {};
    put_str(s);
    send_text_buf();
  endtask

  task automatic send_with_byte(input string head, input logic [7:0] b, input string tail);
    text_buf = {};
    put_str(head);
    text_buf.push_back(b);
    put_str(tail);
    send_text_buf();
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // long hold-off requested by a test
      if (hold_req != 0) begin
        out_ready_i = 1'b0;
        repeat (hold_req) @(negedge clk_i);
        hold_req = 0;
      end
      stall = take_gaps ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_req == 0);
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Compare each result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_addresses.size() == 0) begin
        note_failure($sformatf("unexpected beat: valid_res %0b address %h",
                               valid_res_o, address_o));
      end else begin
        oldest = expected_addresses.pop_front();
        if (valid_res_o !== oldest.ok)
          note_failure($sformatf("valid_res expected %0b got %0b", oldest.ok, valid_res_o));
        if (address_o !== oldest.addr)
          note_failure($sformatf("address expected %h got %h", oldest.addr, address_o));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_part_forms();
    send_str("1.2.3.4");
    send_str("255.255.255.255");
    send_str("0");
    send_str("4294967295");
    send_str("0x7F.0XAB.0xcd.0Xef");
    send_str("0x");
    send_str("0129.08");
    send_str("1.2.0x");
  endtask

  task automatic test_range_limits();
    send_str("1.16777215");
    send_str("1.16777216");
    send_str("1.2.65535");
    send_str("1.2.65536");
    send_str("1.2.3.256");
    send_str("4294967296");
  endtask

  task automatic test_malformed_texts();
    send_str("");
    send_str(".1");
    send_str("1.");
    send_str("1..2");
    send_str("1.2.3.4.5");
    send_str("1a");
    send_str("0xg");
    // whitespace terminators with trailing junk, and their neighbours
    for (int c = ipv4p_pkg::CH_TAB; c <= ipv4p_pkg::CH_CR; c++)
      send_with_byte("10", c[7:0], "x");
    send_with_byte("10", ipv4p_pkg::CH_TAB - 8'd1, "");
    send_with_byte("10", ipv4p_pkg::CH_CR + 8'd1, "");
    send_with_byte("7", ipv4p_pkg::CH_NUL, "zz");
    send_with_byte("1", 8'hFF, "");
    send_with_byte("1 ", 8'h80, "");
  endtask

  task automatic test_back_pressure();
    send_gaps = 1'b0;
    hold_req  = 200;
    repeat (40) send_str("9");
    send_gaps = 1'b1;
  endtask

  // Mostly well-formed texts with random content, some noise and broken ones
  task automatic build_random_text();
    int unsigned kind, nparts, lim_bits, form, k;
    logic [31:0] v, max_v;
    string       digits, hexd;
    text_buf = {};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom));
      return;
    end
    nparts = $urandom_range(1, 4);
    if ($urandom_range(0, 15) == 0) nparts = 5;
    for (int i = 0; i < nparts; i++) begin
      if (i != 0) text_buf.push_back(ipv4p_pkg::CH_DOT);
      lim_bits = (i == nparts - 1) ? 32 - 8 * (nparts - 1) : 8;
      max_v    = (lim_bits >= 32) ? 32'hFFFF_FFFF : (32'd1 << lim_bits) - 32'd1;
      case ($urandom_range(0, 7))
        0:       v = $urandom;
        1:       v = max_v;
        2:       v = max_v + 32'd1;
        default: v = $urandom_range(0, max_v);
      endcase
      form = $urandom_range(0, 3);
      case (form)
        0: begin
          digits = $sformatf("0%0o", v);
          // octal accepts 8 and 9 as digits
          if (digits.len() > 1 && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, digits.len() - 1);
            digits.putc(k, ipv4p_pkg::CH_NINE - 8'($urandom_range(0, 1)));
          end
        end
        1: begin
          hexd = ($urandom_range(0, 15) == 0) ? "" : $sformatf("%0h", v);
          if ($urandom_range(0, 1)) hexd = hexd.toupper();
          digits = {"0", ($urandom_range(0, 1) ? "x" : "X"), hexd};
        end
        default: begin
          digits = $sformatf("%0d", v);
          // extra digits enlarge the value, possibly past the range limit or 32 bits
          if ($urandom_range(0, 15) == 0) digits = {digits, "37"};
        end
      endcase
      put_str(digits);
    end
    case ($urandom_range(0, 5))
      0: begin
        text_buf.push_back($urandom_range(0, 1) ? ipv4p_pkg::CH_SPACE :
                           8'($urandom_range(ipv4p_pkg::CH_TAB, ipv4p_pkg::CH_CR)));
        repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom));
      end
      1: begin
        text_buf.push_back(ipv4p_pkg::CH_NUL);
        repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom));
      end
      default: ;
    endcase
    if (kind == 1) text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
  endtask

  task automatic test_random_texts();
    int unsigned first;
    first = chars_sent;
    while (chars_sent - first < 1000) begin
      // alternate stretches with and without idling on each side
      if ($urandom_range(0, 19) == 0) send_gaps = !send_gaps;
      if ($urandom_range(0, 19) == 0) take_gaps = !take_gaps;
      build_random_text();
      send_text_buf();
    end
    send_gaps = 1'b1;
    take_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    char_code_i     = '0;
    end_of_string_i = 1'b0;
    fail_count      = 0;
    chars_sent      = 0;
    hold_req        = 0;
    send_gaps       = 1'b1;
    take_gaps       = 1'b1;
    clear_parser();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_part_forms();
    test_range_limits();
    test_malformed_texts();
    test_back_pressure();
    test_random_texts();

    while (expected_addresses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_addresses.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
design/ipv4p_pkg.sv
design/ipv4p_step.sv
design/ipv4_dotted_address_parser_core.sv
bench/tb.sv
